/* hw/rtl/jkiss64_random_generator_assert.svh */
// Assertion macros for the checker file.
`ifndef JKISS64_RANDOM_GENERATOR_ASSERT_SVH
`define JKISS64_RANDOM_GENERATOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define JK64_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("jk64 check failed");

// Next-cycle implication, disabled while reset is low.
`define JK64_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("jk64 check failed");

`endif

/* hw/rtl/jk64_pkg.sv */
`default_nettype none

package jk64_pkg;

  localparam int unsigned MaxBurst = 16;
  localparam int unsigned CntW     = $clog2(MaxBurst + 1);

  localparam int unsigned CfgIdxW  = 3;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_LCG_MUL    = 3'd0,
    CFG_LCG_INC    = 3'd1,
    CFG_MWC_MUL    = 3'd2,
    CFG_SEED_LCG   = 3'd3,
    CFG_SEED_XS    = 3'd4,
    CFG_SEED_MWC_V = 3'd5,
    CFG_SEED_MWC_C = 3'd6
  } cfg_idx_e;

  localparam logic [31:0] RstLcgMul    = 32'd314527869;
  localparam logic [31:0] RstLcgInc    = 32'd1234567;
  localparam logic [31:0] RstMwcMul    = 32'd4294584393;
  localparam logic [31:0] RstSeedLcg   = 32'd123456789;
  localparam logic [31:0] RstSeedXs    = 32'd987654321;
  localparam logic [31:0] RstSeedMwcV  = 32'd43219876;
  localparam logic [31:0] RstSeedMwcC  = 32'd6543217;

  typedef enum logic {
    KIND_DRAW   = 1'b0,
    KIND_RELOAD = 1'b1
  } kind_e;

  typedef struct packed {
    logic       kind;
    logic [4:0] count;
  } in_item_t;

  typedef struct packed {
    logic [31:0] value;
    logic        last;
  } out_item_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic load_seeds;  // copy seed registers into the state
    logic advance;     // step all three generators
    logic move;        // load output register with the current sum
    logic last;        // last flag for the moved item
  } dp_cmd_t;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_e;

endpackage

`default_nettype wire

/* hw/rtl/jk64_ctrl.sv */
`default_nettype none

module jk64_ctrl
  import jk64_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire in_item_t in_item_i,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  output dp_cmd_t       cmd_o
);

  state_e          state_q, state_d;
  logic [CntW-1:0] rem_q, rem_d;
  logic            pend_q, pend_d;       // state holds a number not yet emitted
  logic            pend_last_q, pend_last_d;
  logic            out_vld_q, out_vld_d;

  logic out_free;
  logic move;
  logic adv;
  logic accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rem_q       <= '0;
      pend_q      <= 1'b0;
      pend_last_q <= 1'b0;
      out_vld_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      rem_q       <= rem_d;
      pend_q      <= pend_d;
      pend_last_q <= pend_last_d;
      out_vld_q   <= out_vld_d;
    end
  end

  always_comb begin
    out_free    = !out_vld_q || !out_stall_i;
    move        = pend_q && out_free;
    in_stall_o  = (state_q != ST_IDLE) || (pend_q && !move);
    accept      = in_valid_i && !in_stall_o;
    adv         = 1'b0;
    state_d     = state_q;
    rem_d       = rem_q;
    cmd_o       = '0;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (in_item_i.kind == KIND_RELOAD) begin
            cmd_o.load_seeds = 1'b1;
          end else if (in_item_i.count != 5'd0) begin
            state_d = ST_RUN;
            if (int'(in_item_i.count) > int'(MaxBurst)) begin
              rem_d = CntW'(MaxBurst);
            end else begin
              rem_d = CntW'(in_item_i.count);
            end
          end
        end
      end
      ST_RUN: begin
        adv = !pend_q || move;
        if (adv) begin
          rem_d = rem_q - CntW'(1);
          if (rem_q == CntW'(1)) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    pend_d      = adv ? 1'b1 : (move ? 1'b0 : pend_q);
    pend_last_d = adv ? (rem_q == CntW'(1)) : pend_last_q;
    out_vld_d   = move || (out_vld_q && out_stall_i);

    cmd_o.advance = adv;
    cmd_o.move    = move;
    cmd_o.last    = pend_last_q;
    out_valid_o   = out_vld_q;
  end

endmodule

`default_nettype wire

/* hw/rtl/jk64_dpath.sv */
`default_nettype none

module jk64_dpath
  import jk64_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [31:0]        cfg_data_i,
  input  wire dp_cmd_t            cmd_i,
  output out_item_t               out_item_o
);

  logic [31:0] lcg_mul_q, lcg_inc_q, mwc_mul_q;
  logic [31:0] seed_lcg_q, seed_xs_q, seed_mwc_v_q, seed_mwc_c_q;

  logic [31:0] lcg_q, lcg_d;
  logic [31:0] xs_q, xs_d;
  logic [31:0] mwc_v_q, mwc_v_d;
  logic [31:0] mwc_c_q, mwc_c_d;

  logic [31:0] value_q;
  logic        last_q;

  logic [63:0] lcg_prod;
  logic [63:0] mwc_prod;
  logic [31:0] xs_a, xs_b;

  // Configuration registers; unknown indexes are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lcg_mul_q    <= RstLcgMul;
      lcg_inc_q    <= RstLcgInc;
      mwc_mul_q    <= RstMwcMul;
      seed_lcg_q   <= RstSeedLcg;
      seed_xs_q    <= RstSeedXs;
      seed_mwc_v_q <= RstSeedMwcV;
      seed_mwc_c_q <= RstSeedMwcC;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_LCG_MUL:    lcg_mul_q    <= cfg_data_i;
        CFG_LCG_INC:    lcg_inc_q    <= cfg_data_i;
        CFG_MWC_MUL:    mwc_mul_q    <= cfg_data_i;
        CFG_SEED_LCG:   seed_lcg_q   <= cfg_data_i;
        CFG_SEED_XS:    seed_xs_q    <= cfg_data_i;
        CFG_SEED_MWC_V: seed_mwc_v_q <= cfg_data_i;
        CFG_SEED_MWC_C: seed_mwc_c_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    lcg_prod = 64'(lcg_mul_q) * 64'(lcg_q) + 64'(lcg_inc_q);
    mwc_prod = 64'(mwc_mul_q) * 64'(mwc_v_q) + 64'(mwc_c_q);
    xs_a     = xs_q ^ (xs_q << 5);
    xs_b     = xs_a ^ (xs_a >> 7);

    lcg_d   = lcg_q;
    xs_d    = xs_q;
    mwc_v_d = mwc_v_q;
    mwc_c_d = mwc_c_q;
    if (cmd_i.load_seeds) begin
      lcg_d   = seed_lcg_q;
      xs_d    = seed_xs_q;
      mwc_v_d = seed_mwc_v_q;
      mwc_c_d = seed_mwc_c_q;
    end else if (cmd_i.advance) begin
      lcg_d   = lcg_prod[31:0];
      xs_d    = xs_b ^ (xs_b << 22);
      mwc_v_d = mwc_prod[31:0];
      mwc_c_d = mwc_prod[63:32];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lcg_q   <= RstSeedLcg;
      xs_q    <= RstSeedXs;
      mwc_v_q <= RstSeedMwcV;
      mwc_c_q <= RstSeedMwcC;
    end else begin
      lcg_q   <= lcg_d;
      xs_q    <= xs_d;
      mwc_v_q <= mwc_v_d;
      mwc_c_q <= mwc_c_d;
    end
  end

  // Output register: sum of the already advanced state.
  always_ff @(posedge clk_i) begin
    if (cmd_i.move) begin
      value_q <= lcg_q + xs_q + mwc_v_q;
      last_q  <= cmd_i.last;
    end
  end

  assign out_item_o.value = value_q;
  assign out_item_o.last  = last_q;

endmodule

`default_nettype wire

/* hw/rtl/jkiss64_random_generator.sv */
// JKISS-64 generator: a draw item of count n (clamped to 16) yields n values.
// Each value is stepped into the state, held pending, then moved to the
// output register. Throughput: one value per cycle while the output is not
// stalled; LCG and MWC each do one 32x32 multiply per step. A draw stalls the
// input until its last value moves out; reload and zero count do not stall.
// Reset (async, low): constants, seeds and state take their reset values.
`default_nettype none

module jkiss64_random_generator
  import jk64_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // request items
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire in_item_t           in_item_i,
  // result items
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output out_item_t               out_item_o,
  // register writes
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [31:0]        cfg_data_i
);

  dp_cmd_t cmd;

  // Registers are plain flops, so a write is always taken.
  assign cfg_ready_o = 1'b1;

  // Controller: burst counter, one-number holding flag between the state
  // registers and the output register, and the output valid.
  jk64_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  // Datapath: config registers, generator state, output value register.
  jk64_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .out_item_o  (out_item_o)
  );

endmodule

`default_nettype wire

/* hw/rtl/jk64_checker.sv */
`default_nettype none
`include "jkiss64_random_generator_assert.svh"

module jk64_checker
  import jk64_pkg::*;
(
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_stall_o,
  input wire in_item_t           in_item_i,
  input wire logic               out_valid_o,
  input wire logic               out_stall_i,
  input wire out_item_t          out_item_o
);

  logic draw_acc;
  logic quick_acc;

  assign draw_acc = in_valid_i && !in_stall_o && (in_item_i.kind == KIND_DRAW)
                    && (in_item_i.count != 5'd0);
  // Reload or zero-count draw: finishes in the accepting cycle.
  assign quick_acc = in_valid_i && !in_stall_o && !draw_acc;

  `JK64_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o)
  `JK64_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_valid_o && out_stall_i, $stable(out_item_o))
  `JK64_ASSERT_NEXT(a_draw_busy, clk_i, rst_ni, draw_acc, in_stall_o)
  `JK64_ASSERT_NEXT(a_quick_done, clk_i, rst_ni, quick_acc, !in_stall_o)
  `JK64_ASSERT_NOW(a_stall_known, clk_i, rst_ni, 1'b1, !$isunknown(in_stall_o))

endmodule

bind jkiss64_random_generator jk64_checker u_jk64_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_item_i   (in_item_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);

`default_nettype wire

/* tb/sv/tb_jkiss64_random_generator.sv */
module tb_jkiss64_random_generator;
  import jk64_pkg::*;

  // Register index that has no register behind it; writes to it must be dropped.
  localparam logic [CfgIdxW-1:0] CfgNoReg = 3'd7;

  localparam int unsigned GapPct       = 21;   // idle/stall chance per cycle, percent
  localparam int unsigned HoldCycles   = 400;  // long output hold-off
  localparam int unsigned HoldAfter    = 400;  // numbers seen before the hold-off starts
  localparam int unsigned SettleCycles = 4;    // block may still chew on a reload
  localparam int unsigned IdleLimit    = 3000; // cycles with no handshake at all
  localparam int unsigned RandPhases   = 6;
  localparam int unsigned PhaseItems   = 75;
  localparam int unsigned SteadyPhase  = 3;    // phase run with no idling on either side

  // Clock and reset
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // DUT hookup
  logic               in_valid  = 1'b0;
  logic               in_stall;
  in_item_t           in_item   = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  out_item_t          out_item;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [31:0]        cfg_data  = '0;

  jkiss64_random_generator uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  // Generator model: our copy of the constants, seeds and running state.
  logic [31:0] lcg_mul, lcg_inc, mwc_mul;
  logic [31:0] seed_lcg, seed_xs, seed_mwc_v, seed_mwc_c;
  logic [31:0] lcg_st, xs_st, mwc_val, mwc_car;

  in_item_t  request_q[$];   // requests waiting to be offered
  out_item_t number_q[$];    // numbers the block owes us, oldest first
  out_item_t head_num;

  logic        no_gaps   = 1'b0;
  logic        hold_done = 1'b0;
  int unsigned hold_left = 0;
  int unsigned quiet_cycles = 0;
  int unsigned errors = 0;
  int unsigned requests_taken = 0;
  int unsigned reloads_taken = 0;
  int unsigned numbers_seen = 0;
  int unsigned reg_writes = 0;
  int unsigned rnd;
  logic [31:0] word;

  // One step of all three generators; returns the combined number.
  function automatic logic [31:0] step_generators();
    logic [31:0] y;
    logic [63:0] prod;
    lcg_st  = lcg_mul * lcg_st + lcg_inc;
    y       = xs_st;
    y       = y ^ (y << 5);
    y       = y ^ (y >> 7);
    y       = y ^ (y << 22);
    xs_st   = y;
    prod    = 64'(mwc_mul) * 64'(mwc_val) + 64'(mwc_car);
    mwc_val = prod[31:0];
    mwc_car = prod[63:32];
    return lcg_st + xs_st + mwc_val;
  endfunction

  // Work out the numbers one accepted request yields and queue them up.
  task automatic predict_numbers(input in_item_t req);
    int unsigned n;
    out_item_t   num;
    if (req.kind == KIND_RELOAD) begin
      lcg_st  = seed_lcg;
      xs_st   = seed_xs;
      mwc_val = seed_mwc_v;
      mwc_car = seed_mwc_c;
      reloads_taken++;
    end else begin
      // count is clamped to the burst limit; zero yields nothing
      n = (req.count > MaxBurst) ? MaxBurst : req.count;
      for (int unsigned k = 0; k < n; k++) begin
        num.value = step_generators();
        num.last  = (k + 1 == n);
        number_q.push_back(num);
      end
    end
  endtask

  task automatic offer(input kind_e kind, input logic [4:0] count);
    in_item_t req;
    req.kind  = kind;
    req.count = count;
    request_q.push_back(req);
  endtask

  // Register write over the config channel; only called while the block is idle.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [31:0] data);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_LCG_MUL:    lcg_mul    = data;
      CFG_LCG_INC:    lcg_inc    = data;
      CFG_MWC_MUL:    mwc_mul    = data;
      CFG_SEED_LCG:   seed_lcg   = data;
      CFG_SEED_XS:    seed_xs    = data;
      CFG_SEED_MWC_V: seed_mwc_v = data;
      CFG_SEED_MWC_C: seed_mwc_c = data;
      default: ;  // unmapped index: nothing changes
    endcase
    reg_writes++;
  endtask

  // Wait until every request is in and every owed number is out, then let a
  // reload or zero-count draw that yields nothing finish inside the block.
  task automatic drain();
    @(posedge clk_i);
    while (request_q.size() != 0 || in_valid || number_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Request driver: holds the item while stalled, otherwise loads the next
  // one or idles at random.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_item  <= '0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_numbers(in_item);
        requests_taken++;
      end
      if (!in_valid || !in_stall) begin
        if (request_q.size() != 0 && (no_gaps || $urandom_range(99) >= GapPct)) begin
          in_valid <= 1'b1;
          in_item  <= request_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Number monitor: checks each accepted number against the oldest one owed,
  // and drives stall (random, plus one long hold-off to back the block up).
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (number_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected number, expected none, actual value %h last %b",
                   $time, out_item.value, out_item.last);
        end else begin
          head_num = number_q.pop_front();
          if (out_item.value !== head_num.value) begin
            errors++;
            $display("%0t: value mismatch, expected %h, actual %h",
                     $time, head_num.value, out_item.value);
          end
          if (out_item.last !== head_num.last) begin
            errors++;
            $display("%0t: last mismatch, expected %b, actual %b",
                     $time, head_num.last, out_item.last);
          end
          numbers_seen++;
        end
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (!hold_done && numbers_seen >= HoldAfter) begin
        // long hold-off while the driver keeps offering
        hold_done = 1'b1;
        hold_left = HoldCycles - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !no_gaps && ($urandom_range(99) < GapPct);
      end
    end
  end

  // Watchdog: too long without any handshake means the block hung.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else if (quiet_cycles >= IdleLimit) begin
      $display("%0t: timeout, no handshake for %0d cycles", $time, IdleLimit);
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles++;
    end
  end

  initial begin
    lcg_mul    = RstLcgMul;
    lcg_inc    = RstLcgInc;
    mwc_mul    = RstMwcMul;
    seed_lcg   = RstSeedLcg;
    seed_xs    = RstSeedXs;
    seed_mwc_v = RstSeedMwcV;
    seed_mwc_c = RstSeedMwcC;
    lcg_st     = RstSeedLcg;
    xs_st      = RstSeedXs;
    mwc_val    = RstSeedMwcV;
    mwc_car    = RstSeedMwcC;

    repeat (10) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    // Directed, reset constants: single, full burst, oversized counts
    // (saturate), zero count (no numbers, state kept), reload replays the
    // sequence, reload ignores its count field, back-to-back reloads.
    offer(KIND_DRAW, 5'd1);
    offer(KIND_DRAW, 5'd16);
    offer(KIND_DRAW, 5'd17);
    offer(KIND_DRAW, 5'd31);
    offer(KIND_DRAW, 5'd0);
    offer(KIND_RELOAD, 5'd31);
    offer(KIND_DRAW, 5'd5);
    offer(KIND_DRAW, 5'd0);
    offer(KIND_RELOAD, 5'd0);
    offer(KIND_RELOAD, 5'd16);
    offer(KIND_DRAW, 5'd2);
    drain();

    // All registers at their maximum; a write to an unmapped index is dropped.
    write_reg(CFG_LCG_MUL, '1);
    write_reg(CFG_LCG_INC, '1);
    write_reg(CFG_MWC_MUL, '1);
    write_reg(CFG_SEED_LCG, '1);
    write_reg(CFG_SEED_XS, '1);
    write_reg(CFG_SEED_MWC_V, '1);
    write_reg(CFG_SEED_MWC_C, '1);
    write_reg(CfgNoReg, $urandom());
    offer(KIND_RELOAD, 5'd0);
    offer(KIND_DRAW, 5'd16);
    offer(KIND_DRAW, 5'd1);
    offer(KIND_DRAW, 5'd8);
    drain();

    // All registers zero, including the xorshift seed: that part stays zero.
    write_reg(CFG_LCG_MUL, '0);
    write_reg(CFG_LCG_INC, '0);
    write_reg(CFG_MWC_MUL, '0);
    write_reg(CFG_SEED_LCG, '0);
    write_reg(CFG_SEED_XS, '0);
    write_reg(CFG_SEED_MWC_V, '0);
    write_reg(CFG_SEED_MWC_C, '0);
    offer(KIND_RELOAD, 5'd1);
    offer(KIND_DRAW, 5'd16);
    offer(KIND_DRAW, 5'd3);
    drain();

    // Random phases: fresh register mix each time, then mostly well-formed
    // draws with some reloads and out-of-range / zero counts.
    for (int p = 0; p < RandPhases; p++) begin
      for (int i = 0; i < 8; i++) begin
        if ($urandom_range(2) != 0) begin
          case ($urandom_range(7))
            0:       word = '0;
            1:       word = '1;
            default: word = $urandom();
          endcase
          write_reg(CfgIdxW'(i), word);
        end
      end
      if ($urandom_range(3) != 0) offer(KIND_RELOAD, 5'($urandom_range(31)));
      no_gaps = (p == SteadyPhase);
      repeat (PhaseItems) begin
        rnd = $urandom_range(99);
        if (rnd < 10)      offer(KIND_RELOAD, 5'($urandom_range(31)));
        else if (rnd < 20) offer(KIND_DRAW, 5'($urandom_range(31)));
        else               offer(KIND_DRAW, 5'($urandom_range(16, 1)));
      end
      drain();
      no_gaps = 1'b0;
    end

    repeat (SettleCycles) @(posedge clk_i);
    $display("Covered %0d requests (%0d reloads) and %0d checked numbers,",
             requests_taken, reloads_taken, numbers_seen);
    $display("with %0d register writes across %0d random settings plus extremes.",
             reg_writes, RandPhases);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
